[sv/dcnf_pkg.sv]
`default_nettype none

package dcnf_pkg;

  // Width of the variable index field on the result channel.
  localparam int unsigned IDX_W = 20;

  // Result queue depth; must be a power of two.
  localparam int unsigned Q_DEPTH = 4;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_P     = 8'h70;

  typedef enum logic [2:0] {
    KIND_LIT        = 3'd0,
    KIND_CLAUSE_END = 3'd1,
    KIND_INPUT_END  = 3'd2,
    KIND_BAD_CHAR   = 3'd3,
    KIND_TOO_LARGE  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    MODE_TOP    = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_CLAUSE = 3'd2,
    MODE_SIGN   = 3'd3,
    MODE_DIGITS = 3'd4
  } mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] variable_index;
    logic             negated;
    logic [7:0]       bad_char;
    logic             last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } slot_t;

endpackage

`default_nettype wire

[sv/dcnf_if.sv]
`default_nettype none

interface dcnf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface dcnf_out_if;
  logic                        valid;
  logic                        ready;
  dcnf_pkg::kind_e             kind;
  logic [dcnf_pkg::IDX_W-1:0]  variable_index;
  logic                        negated;
  logic [7:0]                  bad_char;
  logic                        last;

  modport source (output valid, output kind, output variable_index, output negated,
                  output bad_char, output last, input ready);
  modport sink   (input valid, input kind, input variable_index, input negated,
                  input bad_char, input last, output ready);
endinterface

`default_nettype wire

[sv/dimacs_cnf_literal_parser.sv]
// Path: a transferred byte is held in the input register, decoded once the output queue
//   has room for two results, and its results are then offered from that queue.
// Throughput: one byte per cycle; a byte yields zero, one or two results, which the result
//   port drains one per ready cycle from a four-entry queue, so input stalls only on backlog.
// Reset (rst_ni low, asynchronous): parser returns to top level, queue empties, halt clears.
`default_nettype none

module dimacs_cnf_literal_parser #(
  parameter int unsigned VAR_BITS = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dcnf_in_if.sink    in_i,
  dcnf_out_if.source out_o
);

  localparam int unsigned AccW = VAR_BITS + 1;

  // Input register: one byte waiting for decode.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       room;
  logic       fire;
  logic       take;

  // Parser state. The accumulator never exceeds 2**VAR_BITS while running.
  dcnf_pkg::mode_e mode_q, mode_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            minus_q, minus_d;
  logic            halted_q, halted_d;

  dcnf_pkg::slot_t slot0, slot1, push0, push1;

  // Decode the held byte once the queue can absorb two results.
  assign fire      = in_valid_q && room;
  assign in_i.ready = !in_valid_q || fire;
  assign take      = in_i.valid && in_i.ready;
  assign in_valid_d = take || (in_valid_q && !fire);

  dcnf_step #(
    .VAR_BITS (VAR_BITS)
  ) u_step (
    .byte_i   (byte_q),
    .mode_i   (mode_q),
    .acc_i    (acc_q),
    .minus_i  (minus_q),
    .halted_i (halted_q),
    .mode_o   (mode_d),
    .acc_o    (acc_d),
    .minus_o  (minus_d),
    .halted_o (halted_d),
    .slot0_o  (slot0),
    .slot1_o  (slot1)
  );

  // Drop results of a byte that is not being decoded this cycle.
  always_comb begin
    push0 = slot0;
    push1 = slot1;
    if (!fire) begin
      push0.valid = 1'b0;
      push1.valid = 1'b0;
    end
  end

  dcnf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .slot0_i (push0),
    .slot1_i (push1),
    .room_o  (room),
    .out_o   (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= dcnf_pkg::MODE_TOP;
      acc_q      <= '0;
      minus_q    <= 1'b0;
      halted_q   <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      // Advance parser state only on a decoded byte; a halted parser holds.
      if (fire) begin
        mode_q   <= mode_d;
        acc_q    <= acc_d;
        minus_q  <= minus_d;
        halted_q <= halted_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.text_byte;
    end
  end

endmodule

`default_nettype wire

[sv/dcnf_step.sv]
`default_nettype none

module dcnf_step #(
  parameter int unsigned VAR_BITS = 20
) (
  input  wire logic [7:0]          byte_i,
  input  dcnf_pkg::mode_e          mode_i,
  input  wire logic [VAR_BITS:0]   acc_i,
  input  wire logic                minus_i,
  input  wire logic                halted_i,
  output dcnf_pkg::mode_e          mode_o,
  output logic [VAR_BITS:0]        acc_o,
  output logic                     minus_o,
  output logic                     halted_o,
  output dcnf_pkg::slot_t          slot0_o,
  output dcnf_pkg::slot_t          slot1_o
);

  localparam int unsigned AccW = VAR_BITS + 1;
  localparam int unsigned IdxW = dcnf_pkg::IDX_W;
  localparam logic [AccW+3:0] Limit = {{(AccW+3){1'b0}}, 1'b1} << VAR_BITS;

  logic            is_space, is_digit, is_nul, is_cp, is_minus, is_plus, is_nl;
  logic [3:0]      dval;
  logic            acc_zero;
  logic [AccW+3:0] acc10;
  logic            too_large;
  logic [AccW-1:0] acc_m1;
  logic [AccW+IdxW-1:0] idx_wide;
  logic [IdxW-1:0] idx;

  // Token-start decode, shared by the first pass and the reprocessed byte.
  logic            at_top;
  dcnf_pkg::mode_e f_mode;
  logic            f_halt;
  logic            f_valid;
  dcnf_pkg::kind_e f_kind;
  logic [7:0]      f_bad;

  always_comb begin
    is_space = byte_i inside {[dcnf_pkg::CH_TAB:dcnf_pkg::CH_CR], dcnf_pkg::CH_SPACE};
    is_digit = byte_i inside {[dcnf_pkg::CH_ZERO:dcnf_pkg::CH_NINE]};
    is_nul   = (byte_i == dcnf_pkg::CH_NUL);
    is_cp    = byte_i inside {dcnf_pkg::CH_C, dcnf_pkg::CH_P};
    is_minus = (byte_i == dcnf_pkg::CH_MINUS);
    is_plus  = (byte_i == dcnf_pkg::CH_PLUS);
    is_nl    = (byte_i == dcnf_pkg::CH_NL);
    dval     = byte_i[3:0];
    acc_zero = (acc_i == '0);
    acc10    = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} + (AccW+4)'(dval);
    too_large = (acc10 > Limit);
    acc_m1   = acc_i - AccW'(1);
    idx_wide = {{IdxW{1'b0}}, acc_m1};
    idx      = idx_wide[IdxW-1:0];
  end

  always_comb begin
    // A terminated digit run falls back to top level on zero, else stays in the clause.
    if (mode_i == dcnf_pkg::MODE_DIGITS) begin
      at_top = acc_zero;
    end else begin
      at_top = (mode_i == dcnf_pkg::MODE_TOP);
    end
    f_mode  = at_top ? dcnf_pkg::MODE_TOP : dcnf_pkg::MODE_CLAUSE;
    f_halt  = 1'b0;
    f_valid = 1'b0;
    f_kind  = dcnf_pkg::KIND_LIT;
    f_bad   = '0;
    if (is_space) begin
      f_halt = 1'b0;
    end else if (at_top && is_nul) begin
      f_halt  = 1'b1;
      f_valid = 1'b1;
      f_kind  = dcnf_pkg::KIND_INPUT_END;
    end else if (at_top && is_cp) begin
      f_mode = dcnf_pkg::MODE_LINE;
    end else if (is_minus || is_plus) begin
      f_mode = dcnf_pkg::MODE_SIGN;
    end else if (is_digit) begin
      f_mode = dcnf_pkg::MODE_DIGITS;
    end else begin
      f_halt  = 1'b1;
      f_valid = 1'b1;
      f_kind  = dcnf_pkg::KIND_BAD_CHAR;
      f_bad   = byte_i;
    end
  end

  // Next state
  always_comb begin
    mode_o   = mode_i;
    acc_o    = acc_i;
    minus_o  = minus_i;
    halted_o = halted_i;
    if (!halted_i) begin
      case (mode_i)
        dcnf_pkg::MODE_TOP, dcnf_pkg::MODE_CLAUSE: begin
          mode_o   = f_mode;
          acc_o    = is_digit ? AccW'(dval) : '0;
          minus_o  = is_minus;
          halted_o = f_halt;
        end
        dcnf_pkg::MODE_LINE: begin
          if (is_nul) begin
            halted_o = 1'b1;
          end else if (is_nl) begin
            mode_o = dcnf_pkg::MODE_TOP;
          end
        end
        dcnf_pkg::MODE_SIGN: begin
          if (is_digit) begin
            mode_o = dcnf_pkg::MODE_DIGITS;
            acc_o  = AccW'(dval);
          end else begin
            halted_o = 1'b1;
          end
        end
        dcnf_pkg::MODE_DIGITS: begin
          if (is_digit) begin
            acc_o    = acc10[AccW-1:0];
            halted_o = too_large;
          end else begin
            mode_o   = f_mode;
            acc_o    = '0;
            minus_o  = is_minus;
            halted_o = f_halt;
          end
        end
        default: begin
          mode_o = dcnf_pkg::MODE_TOP;
        end
      endcase
    end
  end

  // Results
  always_comb begin
    slot0_o = '0;
    slot1_o = '0;
    if (!halted_i) begin
      case (mode_i)
        dcnf_pkg::MODE_TOP, dcnf_pkg::MODE_CLAUSE: begin
          slot0_o.valid        = f_valid;
          slot0_o.res.kind     = f_kind;
          slot0_o.res.bad_char = f_bad;
        end
        dcnf_pkg::MODE_LINE: begin
          slot0_o.valid    = is_nul;
          slot0_o.res.kind = dcnf_pkg::KIND_INPUT_END;
        end
        dcnf_pkg::MODE_SIGN: begin
          slot0_o.valid        = !is_digit;
          slot0_o.res.kind     = dcnf_pkg::KIND_BAD_CHAR;
          slot0_o.res.bad_char = byte_i;
        end
        dcnf_pkg::MODE_DIGITS: begin
          if (is_digit) begin
            slot0_o.valid    = too_large;
            slot0_o.res.kind = dcnf_pkg::KIND_TOO_LARGE;
          end else begin
            slot0_o.valid = 1'b1;
            if (acc_zero) begin
              slot0_o.res.kind = dcnf_pkg::KIND_CLAUSE_END;
            end else begin
              slot0_o.res.kind           = dcnf_pkg::KIND_LIT;
              slot0_o.res.variable_index = idx;
              slot0_o.res.negated        = minus_i;
            end
            slot1_o.valid        = f_valid;
            slot1_o.res.kind     = f_kind;
            slot1_o.res.bad_char = f_bad;
          end
        end
        default: begin
          slot0_o = '0;
        end
      endcase
    end
    slot0_o.res.last = !slot1_o.valid;
    slot1_o.res.last = 1'b1;
  end

endmodule

`default_nettype wire

[sv/dcnf_outq.sv]
`default_nettype none

module dcnf_outq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  dcnf_pkg::slot_t  slot0_i,
  input  dcnf_pkg::slot_t  slot1_i,
  output logic             room_o,
  dcnf_out_if.source       out_o
);

  localparam int unsigned Depth = dcnf_pkg::Q_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dcnf_pkg::result_t entry_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d, push_n;
  logic            pop;
  dcnf_pkg::result_t head;

  always_comb begin
    head    = entry_q[rd_q];
    pop     = out_o.valid && out_o.ready;
    push_n  = CntW'(slot0_i.valid) + CntW'(slot1_i.valid);
    wr_next = wr_q + PtrW'(1);
    wr_d    = wr_q + push_n[PtrW-1:0];
    rd_d    = rd_q + PtrW'(pop);
    cnt_d   = cnt_q + push_n - CntW'(pop);
    // Always leave space for a two-result byte.
    room_o  = (cnt_q <= CntW'(Depth - 2));
  end

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.kind           = head.kind;
  assign out_o.variable_index = head.variable_index;
  assign out_o.negated        = head.negated;
  assign out_o.bad_char       = head.bad_char;
  assign out_o.last           = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot0_i.valid) begin
      entry_q[wr_q] <= slot0_i.res;
    end
    if (slot1_i.valid) begin
      entry_q[wr_next] <= slot1_i.res;
    end
  end

endmodule

`default_nettype wire

[sv/dcnf_check.sv]
`default_nettype none

module dcnf_check (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input dcnf_pkg::kind_e                 kind_i,
  input wire logic [dcnf_pkg::IDX_W-1:0] idx_i,
  input wire logic                       neg_i,
  input wire logic [7:0]                 bad_i,
  input wire logic                       last_i
);

  logic terminal;
  assign terminal = (kind_i == dcnf_pkg::KIND_INPUT_END) ||
                    (kind_i == dcnf_pkg::KIND_BAD_CHAR) ||
                    (kind_i == dcnf_pkg::KIND_TOO_LARGE);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({kind_i, idx_i, neg_i, bad_i, last_i}))
    else $error("result changed while stalled");

  a_terminal_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && terminal |-> last_i)
    else $error("terminal result not marked last");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && terminal |=> !out_valid_i)
    else $error("result after halt");

  a_lit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != dcnf_pkg::KIND_LIT |-> idx_i == '0 && !neg_i)
    else $error("literal fields set on non-literal");

  a_bad_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != dcnf_pkg::KIND_BAD_CHAR |-> bad_i == '0)
    else $error("bad_char set on other kind");

endmodule

bind dimacs_cnf_literal_parser dcnf_check u_dcnf_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .idx_i       (out_o.variable_index),
  .neg_i       (out_o.negated),
  .bad_i       (out_o.bad_char),
  .last_i      (out_o.last)
);

`default_nettype wire

[tb/tb_dimacs_cnf_literal_parser.sv]
`timescale 1ns / 1ps

module tb_dimacs_cnf_literal_parser;
  import dcnf_pkg::*;

  localparam int unsigned VAR_BITS = 20;
  localparam longint unsigned VALUE_LIMIT = 64'd1 << VAR_BITS;
  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 20;
  localparam int unsigned TRAILING_BYTES = 6;

  // Blanks that the package leaves unnamed.
  localparam logic [7:0] CH_VT = 8'd11;
  localparam logic [7:0] CH_FF = 8'd12;

  // Ways to end the run. The parser halts for good after the first end or error and reset
  // is applied only once, so each run draws one of these at random.
  typedef enum int {
    HALT_NUL_TOP,
    HALT_NUL_LINE,
    HALT_NUL_SIGN,
    HALT_NUL_DIGITS,
    HALT_NUL_CLAUSE,
    HALT_LETTER_CLAUSE,
    HALT_GLUED_BYTE,
    HALT_SIGN_ALONE,
    HALT_BAD_TOP,
    HALT_TOO_LARGE,
    HALT_COUNT
  } halt_case_e;

  logic clk_i;
  logic rst_ni;

  dcnf_in_if  text_if ();
  dcnf_out_if token_if ();

  dimacs_cnf_literal_parser #(
    .VAR_BITS(VAR_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (text_if),
    .out_o (token_if)
  );

  // Parser state mirrored from the spec.
  mode_e       parse_mode;
  int unsigned parse_acc;
  bit          parse_minus;
  bit          parse_halted;

  // Results of the byte being parsed, then all results still owed by the block.
  result_t step_tokens[$];
  result_t tokens_due[$];

  bit          text_calm;
  bit          token_calm;
  halt_case_e  halt_case;
  int unsigned bytes_sent;
  int unsigned bytes_dropped;
  int unsigned tokens_checked;
  int unsigned literals_seen;
  int unsigned clause_ends_seen;
  int unsigned error_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit is_blank(input logic [7:0] b);
    return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic result_t token(input kind_e k, input logic [IDX_W-1:0] idx,
                                    input logic neg, input logic [7:0] bad);
    result_t r;
    r.kind           = k;
    r.variable_index = idx;
    r.negated        = neg;
    r.bad_char       = bad;
    r.last           = 1'b0;
    return r;
  endfunction

  // Sign or digit opens a number; anything else is an error that halts the parser.
  function automatic void begin_number(input logic [7:0] b);
    parse_acc   = 0;
    parse_minus = 1'b0;
    if (b == CH_MINUS) begin
      parse_minus = 1'b1;
      parse_mode  = MODE_SIGN;
    end else if (b == CH_PLUS) begin
      parse_mode = MODE_SIGN;
    end else if (is_digit(b)) begin
      parse_acc  = b - CH_ZERO;
      parse_mode = MODE_DIGITS;
    end else begin
      parse_halted = 1'b1;
      step_tokens.push_back(token(KIND_BAD_CHAR, '0, 1'b0, b));
    end
  endfunction

  // Advance the mirrored parser by one accepted byte and queue the results it owes.
  // A byte that ends a digit run is looked at a second time in the new mode.
  function automatic void parse_text_byte(input logic [7:0] b);
    bit again;
    if (parse_halted) return;
    step_tokens.delete();
    for (int pass = 0; pass < 2 && !parse_halted; pass++) begin
      again = 1'b0;
      case (parse_mode)
        MODE_TOP: begin
          if (is_blank(b)) begin
          end else if (b == CH_NUL) begin
            parse_halted = 1'b1;
            step_tokens.push_back(token(KIND_INPUT_END, '0, 1'b0, '0));
          end else if (b == CH_C || b == CH_P) begin
            parse_mode = MODE_LINE;
          end else begin
            begin_number(b);
          end
        end
        MODE_LINE: begin
          if (b == CH_NUL) begin
            parse_halted = 1'b1;
            step_tokens.push_back(token(KIND_INPUT_END, '0, 1'b0, '0));
          end else if (b == CH_NL) begin
            parse_mode = MODE_TOP;
          end
        end
        MODE_CLAUSE: begin
          if (!is_blank(b)) begin_number(b);
        end
        MODE_SIGN: begin
          if (is_digit(b)) begin
            parse_acc  = b - CH_ZERO;
            parse_mode = MODE_DIGITS;
          end else begin
            parse_halted = 1'b1;
            step_tokens.push_back(token(KIND_BAD_CHAR, '0, 1'b0, b));
          end
        end
        MODE_DIGITS: begin
          if (is_digit(b)) begin
            parse_acc = parse_acc * 10 + (b - CH_ZERO);
            if (parse_acc > VALUE_LIMIT) begin
              parse_halted = 1'b1;
              step_tokens.push_back(token(KIND_TOO_LARGE, '0, 1'b0, '0));
            end
          end else begin
            if (parse_acc == 0) begin
              step_tokens.push_back(token(KIND_CLAUSE_END, '0, 1'b0, '0));
              parse_mode = MODE_TOP;
            end else begin
              step_tokens.push_back(token(KIND_LIT, IDX_W'(parse_acc - 1), parse_minus, '0));
              parse_mode = MODE_CLAUSE;
            end
            parse_acc   = 0;
            parse_minus = 1'b0;
            again       = 1'b1;
          end
        end
        default: begin
          parse_mode = MODE_TOP;
          again      = 1'b1;
        end
      endcase
      if (!again) break;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endfunction

  // Offer one byte, hold it until the transfer, then idle for a random gap. Valid stays
  // high across back-to-back bytes so it never sees two updates in one step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
    if (parse_halted) bytes_dropped++;
    else bytes_sent++;
    parse_text_byte(b);
    if ($urandom_range(0, 39) == 0) text_calm = !text_calm;
    gap = text_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_blanks();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 5))
        0:       send_byte(CH_TAB);
        1:       send_byte(CH_NL);
        2:       send_byte(CH_VT);
        3:       send_byte(CH_FF);
        4:       send_byte(CH_CR);
        default: send_byte(CH_SPACE);
      endcase
    end
  endtask

  // Send one number with a random sign and optional leading zeros. A signed number may
  // be glued to what came before, since a sign always ends the previous digit run.
  task automatic send_number(input int unsigned value);
    int unsigned sign_pick;
    sign_pick = $urandom_range(0, 3);
    if (sign_pick < 2 || $urandom_range(0, 5) != 0) send_blanks();
    if (sign_pick == 2) send_byte(CH_MINUS);
    if (sign_pick == 3) send_byte(CH_PLUS);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) send_byte(CH_ZERO);
    send_str($sformatf("%0d", value));
  endtask

  // Mostly small variables, with the top of the range now and then.
  function automatic int unsigned draw_var_value();
    case ($urandom_range(0, 19))
      0:       return VALUE_LIMIT;
      1:       return VALUE_LIMIT - 1;
      2, 3:    return $urandom_range(1, VALUE_LIMIT);
      4, 5, 6: return $urandom_range(1, 5000);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // Any nonzero, non-blank byte that cannot start a number; at top level 'c' and 'p' open a line instead.
  function automatic logic [7:0] draw_stray_byte(input bit at_top);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (is_blank(b) || is_digit(b) || b == CH_MINUS || b == CH_PLUS ||
           (at_top && (b == CH_C || b == CH_P)));
    return b;
  endfunction

  // Header with a high byte, every blank, the largest and the smallest variable, leading
  // zeros, a sign glued to a literal, and minus zero whose end byte opens a comment.
  task automatic test_directed_text();
    send_byte(CH_P);
    send_byte(CH_SPACE);
    send_byte(8'hFF);
    send_byte(CH_NL);
    send_byte(CH_TAB);
    send_byte(CH_NL);
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_byte(CH_CR);
    send_byte(CH_SPACE);
    send_str($sformatf("+%0d 1-007 -0c", VALUE_LIMIT));
    send_byte(CH_NL);
  endtask

  // Well-formed text with random content: comment lines full of arbitrary bytes, blank
  // runs, and clauses of random literals closed by some spelling of zero.
  task automatic test_random_text();
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  b;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        if ($urandom_range(0, 2) != 0) send_blanks();
        send_byte($urandom_range(0, 1) ? CH_C : CH_P);
        repeat ($urandom_range(0, 12)) begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
          send_byte(b);
        end
        send_byte(CH_NL);
      end else if (pick == 1) begin
        send_blanks();
      end else begin
        repeat ($urandom_range(0, 5)) send_number(draw_var_value());
        send_number(0);
      end
    end
  endtask

  // End the input or break it in one of the halting ways, then keep sending; the halted
  // parser must drop every further byte.
  task automatic test_halting_cases();
    halt_case = halt_case_e'($urandom_range(0, HALT_COUNT - 1));
    case (halt_case)
      HALT_NUL_TOP: begin
        send_byte(CH_SPACE);
        send_byte(CH_NUL);
      end
      HALT_NUL_LINE: begin
        send_byte(CH_C);
        send_str(" x");
        send_byte(CH_NUL);
      end
      HALT_NUL_SIGN: begin
        send_str("5 ");
        send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        send_byte(CH_NUL);
      end
      HALT_NUL_DIGITS: begin
        // zero gives clause end plus input end; otherwise a literal plus an error
        send_str($sformatf("%0d", $urandom_range(0, 3)));
        send_byte(CH_NUL);
      end
      HALT_NUL_CLAUSE: begin
        send_str("7");
        send_byte(CH_TAB);
        send_byte(CH_NUL);
      end
      HALT_LETTER_CLAUSE: begin
        send_str("2 ");
        send_byte($urandom_range(0, 1) ? CH_C : CH_P);
      end
      HALT_GLUED_BYTE: begin
        send_str("-12");
        send_byte(draw_stray_byte(1'b0));
      end
      HALT_SIGN_ALONE: begin
        logic [7:0] b;
        send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        do b = 8'($urandom_range(0, 255)); while (is_digit(b));
        send_byte(b);
      end
      HALT_BAD_TOP: begin
        send_byte(draw_stray_byte(1'b1));
      end
      default: begin
        if ($urandom_range(0, 1)) send_byte(CH_MINUS);
        if ($urandom_range(0, 2) == 0) send_str($sformatf("%0d", VALUE_LIMIT + 1));
        else send_str($sformatf("%0d", VALUE_LIMIT + 1 + $urandom_range(0, 9_000_000)));
      end
    endcase
    repeat (TRAILING_BYTES) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Result side: stall for a random count, take one transfer, check it against the
  // oldest result owed.
  initial begin : token_sink
    result_t     got;
    result_t     want;
    int unsigned stall;
    token_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) token_calm = !token_calm;
      stall = token_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        token_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      token_if.ready <= 1'b1;
      do @(posedge clk_i); while (!token_if.valid);
      got.kind           = token_if.kind;
      got.variable_index = token_if.variable_index;
      got.negated        = token_if.negated;
      got.bad_char       = token_if.bad_char;
      got.last           = token_if.last;
      if (tokens_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual kind=%0d idx=%0d neg=%0b bad=%0h last=%0b",
                   $time, got.kind, got.variable_index, got.negated, got.bad_char, got.last);
      end else begin
        want = tokens_due.pop_front();
        tokens_checked++;
        if (want.kind == KIND_LIT) literals_seen++;
        if (want.kind == KIND_CLAUSE_END) clause_ends_seen++;
        if (got.kind !== want.kind || got.variable_index !== want.variable_index ||
            got.negated !== want.negated || got.bad_char !== want.bad_char ||
            got.last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result mismatch: expected kind=%0d idx=%0d neg=%0b bad=%0h last=%0b, actual kind=%0d idx=%0d neg=%0b bad=%0h last=%0b",
                     $time, want.kind, want.variable_index, want.negated, want.bad_char,
                     want.last, got.kind, got.variable_index, got.negated, got.bad_char,
                     got.last);
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni            = 1'b0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    parse_mode        = MODE_TOP;
    parse_acc         = 0;
    parse_minus       = 1'b0;
    parse_halted      = 1'b0;
    text_calm         = 1'b0;
    token_calm        = 1'b0;
    bytes_sent        = 0;
    bytes_dropped     = 0;
    tokens_checked    = 0;
    literals_seen     = 0;
    clause_ends_seen  = 0;
    error_count       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_text();
    test_random_text();
    test_halting_cases();
    text_if.valid <= 1'b0;

    // Drain what is owed, then watch a while longer for stray results.
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Parsed %0d text bytes into %0d checked results (%0d literals, %0d clause ends).",
             bytes_sent, tokens_checked, literals_seen, clause_ends_seen);
    $display("Run halted via %s; %0d later bytes were dropped.", halt_case.name(),
             bytes_dropped);
    if (error_count == 0) begin
      $display("PASS dimacs_cnf_literal_parser");
    end else begin
      $display("FAIL dimacs_cnf_literal_parser");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still owed", tokens_due.size());
    $display("FAIL dimacs_cnf_literal_parser");
    $finish;
  end

endmodule
